@@ hdl/hwa_pkg.sv @@
// Shared types, constants and helpers of the weighted HPWL accumulator.
// No dependencies; imported by every hwa_* module and by the top level.
package hwa_pkg;

    localparam int POS_W   = 32;
    localparam int OFF_W   = 21;
    localparam int LOC_W   = 31;
    localparam int WGT_W   = 16;
    localparam int SPAN_W  = 33;
    localparam int LEN_W   = 49;
    localparam int TOTAL_W = 63;

    localparam logic signed [POS_W-1:0] LOC_MIN = {1'b1, {(POS_W-1){1'b0}}};
    localparam logic signed [POS_W-1:0] LOC_MAX = {1'b0, {(POS_W-1){1'b1}}};
    localparam logic [TOTAL_W-1:0]      TOTAL_MAX = {TOTAL_W{1'b1}};

    typedef struct packed {
        logic signed [POS_W-1:0] px;
        logic signed [POS_W-1:0] py;
        logic signed [LOC_W-1:0] vx;
        logic signed [LOC_W-1:0] vy;
        logic [WGT_W-1:0]        weight;
        logic                    is_io;
        logic                    last_pin;
        logic                    last_net;
    } hwa_pin_t;

    typedef struct packed {
        logic signed [POS_W-1:0] xmax;
        logic signed [POS_W-1:0] xmin;
        logic signed [POS_W-1:0] ymax;
        logic signed [POS_W-1:0] ymin;
    } hwa_bbox_t;

    typedef struct packed {
        hwa_bbox_t        box;
        logic [WGT_W-1:0] weight;
        logic             counted;
        logic             last_net;
    } hwa_net_t;

    typedef struct packed {
        logic [SPAN_W-1:0] span;
        logic [WGT_W-1:0]  weight;
        logic              counted;
        logic              last_net;
    } hwa_span_t;

    typedef struct packed {
        logic [LEN_W-1:0] len;
        logic             counted;
        logic             last_net;
    } hwa_len_t;

    localparam hwa_bbox_t BOX_EMPTY = '{xmax: LOC_MIN, xmin: LOC_MAX,
                                       ymax: LOC_MIN, ymin: LOC_MAX};

    function automatic hwa_bbox_t widen(input hwa_bbox_t b,
                                        input logic signed [POS_W-1:0] x,
                                        input logic signed [POS_W-1:0] y);
        hwa_bbox_t r;
        r = b;
        if (x > b.xmax) r.xmax = x;
        if (x < b.xmin) r.xmin = x;
        if (y > b.ymax) r.ymax = y;
        if (y < b.ymin) r.ymin = y;
        return r;
    endfunction

endpackage

@@ hdl/weighted_hpwl_accumulator_top.sv @@
// Top level of the weighted HPWL accumulator: input register, config register.
// Depends on hwa_pkg, hwa_box, hwa_len and hwa_acc.
//
// Accepts one pin transaction per clock for as long as results are taken. A net's
// result, after its last pin enters the input register, is registered in turn through
// box close (pin and virtual pin compares), span, weight multiply and total update.
// The one-cycle rate is set by the bounding box feedback in hwa_box, which folds
// each pin into the box in the cycle it leaves the input register. Nets with
// fewer than two pins give a zero-length transaction and leave the total alone;
// the total saturates at 2^63-1 and clears after a transaction with last_net.
module weighted_hpwl_accumulator_top (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  cfg_wr_en,
    input  logic                                  cfg_wr_data,
    input  logic                                  s_valid,
    output logic                                  s_ready,
    input  logic signed [hwa_pkg::OFF_W-1:0]      s_pin_off_x,
    input  logic signed [hwa_pkg::OFF_W-1:0]      s_pin_off_y,
    input  logic signed [hwa_pkg::LOC_W-1:0]      s_cell_x,
    input  logic signed [hwa_pkg::LOC_W-1:0]      s_cell_y,
    input  logic [hwa_pkg::WGT_W-1:0]             s_net_weight,
    input  logic                                  s_net_is_io,
    input  logic signed [hwa_pkg::LOC_W-1:0]      s_virt_x,
    input  logic signed [hwa_pkg::LOC_W-1:0]      s_virt_y,
    input  logic                                  s_last_pin,
    input  logic                                  s_last_net,
    output logic                                  m_valid,
    input  logic                                  m_ready,
    output logic [hwa_pkg::LEN_W-1:0]             m_net_length,
    output logic                                  m_net_counted,
    output logic [hwa_pkg::TOTAL_W-1:0]           m_total_length,
    output logic                                  m_is_final
);
    import hwa_pkg::*;

    logic     use_vp_reg;
    logic     a_valid_reg;
    hwa_pin_t a_reg;
    logic     pin_take;
    logic     net_valid, net_ready;
    hwa_net_t net;
    logic     len_valid, len_ready;
    hwa_len_t len;

    assign s_ready = !a_valid_reg || pin_take;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            use_vp_reg  <= 1'b1;
            a_valid_reg <= 1'b0;
        end else begin
            if (cfg_wr_en) use_vp_reg <= cfg_wr_data;
            if (s_ready) a_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            a_reg.px       <= POS_W'(s_pin_off_x) + POS_W'(s_cell_x);
            a_reg.py       <= POS_W'(s_pin_off_y) + POS_W'(s_cell_y);
            a_reg.vx       <= s_virt_x;
            a_reg.vy       <= s_virt_y;
            a_reg.weight   <= s_net_weight;
            a_reg.is_io    <= s_net_is_io;
            a_reg.last_pin <= s_last_pin;
            a_reg.last_net <= s_last_net;
        end
    end

    hwa_box u_box (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .use_vp    (use_vp_reg),
        .pin_valid (a_valid_reg),
        .pin       (a_reg),
        .pin_take  (pin_take),
        .net_valid (net_valid),
        .net       (net),
        .net_ready (net_ready)
    );

    hwa_len u_len (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .net_valid (net_valid),
        .net       (net),
        .net_ready (net_ready),
        .len_valid (len_valid),
        .len       (len),
        .len_ready (len_ready)
    );

    hwa_acc u_acc (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .len_valid      (len_valid),
        .len            (len),
        .len_ready      (len_ready),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_net_length   (m_net_length),
        .m_net_counted  (m_net_counted),
        .m_total_length (m_total_length),
        .m_is_final     (m_is_final)
    );

endmodule

@@ hdl/hwa_box.sv @@
// Bounding box tracker: widens the net's box per pin, closes it on the last pin.
// Depends on hwa_pkg; feeds hwa_len.
module hwa_box (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              use_vp,
    input  logic              pin_valid,
    input  hwa_pkg::hwa_pin_t pin,
    output logic              pin_take,
    output logic              net_valid,
    output hwa_pkg::hwa_net_t net,
    input  logic              net_ready
);
    import hwa_pkg::*;

    hwa_bbox_t  box_reg, box_next;
    logic [1:0] pins_reg, pins_next;
    logic       valid_reg;
    hwa_net_t   net_reg;

    hwa_bbox_t  box_pin, box_fin;
    logic [1:0] pins_inc;
    logic       out_ready;

    assign out_ready = !valid_reg || net_ready;
    assign pin_take  = pin_valid && (!pin.last_pin || out_ready);

    always_comb begin
        box_pin  = widen(box_reg, pin.px, pin.py);
        pins_inc = (pins_reg == 2'd2) ? 2'd2 : pins_reg + 2'd1;
        box_fin  = box_pin;
        if (pin.is_io && use_vp) begin
            box_fin = widen(box_pin, POS_W'(pin.vx), POS_W'(pin.vy));
        end
        box_next  = box_reg;
        pins_next = pins_reg;
        if (pin_take) begin
            if (pin.last_pin) begin
                box_next  = BOX_EMPTY;
                pins_next = 2'd0;
            end else begin
                box_next  = box_pin;
                pins_next = pins_inc;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            box_reg   <= BOX_EMPTY;
            pins_reg  <= 2'd0;
            valid_reg <= 1'b0;
        end else begin
            box_reg  <= box_next;
            pins_reg <= pins_next;
            if (pin_take && pin.last_pin) begin
                valid_reg <= 1'b1;
            end else if (net_ready) begin
                valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (pin_take && pin.last_pin) begin
            net_reg.box      <= box_fin;
            net_reg.weight   <= pin.weight;
            net_reg.counted  <= (pins_inc == 2'd2);
            net_reg.last_net <= pin.last_net;
        end
    end

    assign net_valid = valid_reg;
    assign net       = net_reg;

    a_pins_sat: assert property (@(posedge aclk) disable iff (!aresetn)
        pins_reg != 2'd3)
        else $error("pin count out of range");

    a_net_end_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        (pin_take && pin.last_pin) |=> (pins_reg == 2'd0 && box_reg == BOX_EMPTY))
        else $error("box not cleared at net end");

endmodule

@@ hdl/hwa_len.sv @@
// Net length stages: span of the box, then weighted length.
// Depends on hwa_pkg; fed by hwa_box, feeds hwa_acc.
module hwa_len (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              net_valid,
    input  hwa_pkg::hwa_net_t net,
    output logic              net_ready,
    output logic              len_valid,
    output hwa_pkg::hwa_len_t len,
    input  logic              len_ready
);
    import hwa_pkg::*;

    logic      c_valid_reg, d_valid_reg;
    hwa_span_t c_reg;
    hwa_len_t  d_reg;
    logic      c_ready, d_ready, c_load, d_load;
    logic [POS_W-1:0] dx, dy;

    assign d_ready   = !d_valid_reg || len_ready;
    assign c_ready   = !c_valid_reg || d_ready;
    assign net_ready = c_ready;
    assign c_load    = net_valid && c_ready;
    assign d_load    = c_valid_reg && d_ready;

    assign dx = POS_W'(net.box.xmax - net.box.xmin);
    assign dy = POS_W'(net.box.ymax - net.box.ymin);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            c_valid_reg <= 1'b0;
            d_valid_reg <= 1'b0;
        end else begin
            if (c_ready) c_valid_reg <= net_valid;
            if (d_ready) d_valid_reg <= c_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (c_load) begin
            c_reg.span     <= {1'b0, dx} + {1'b0, dy};
            c_reg.weight   <= net.weight;
            c_reg.counted  <= net.counted;
            c_reg.last_net <= net.last_net;
        end
        if (d_load) begin
            d_reg.len      <= c_reg.counted ? LEN_W'(c_reg.span) * LEN_W'(c_reg.weight)
                                            : '0;
            d_reg.counted  <= c_reg.counted;
            d_reg.last_net <= c_reg.last_net;
        end
    end

    assign len_valid = d_valid_reg;
    assign len       = d_reg;

endmodule

@@ hdl/hwa_acc.sv @@
// Saturating running total and the result register.
// Depends on hwa_pkg; fed by hwa_len, drives the result channel.
module hwa_acc (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         len_valid,
    input  hwa_pkg::hwa_len_t            len,
    output logic                         len_ready,
    output logic                         m_valid,
    input  logic                         m_ready,
    output logic [hwa_pkg::LEN_W-1:0]    m_net_length,
    output logic                         m_net_counted,
    output logic [hwa_pkg::TOTAL_W-1:0]  m_total_length,
    output logic                         m_is_final
);
    import hwa_pkg::*;

    logic [TOTAL_W-1:0] total_reg, total_next, total_sat;
    logic [TOTAL_W:0]   sum;
    logic               valid_reg, take;
    logic [LEN_W-1:0]   len_reg;
    logic               counted_reg, final_reg;
    logic [TOTAL_W-1:0] out_total_reg;

    assign len_ready = !valid_reg || m_ready;
    assign take      = len_valid && len_ready;

    always_comb begin
        sum        = {1'b0, total_reg} + (TOTAL_W+1)'(len.len);
        total_sat  = sum[TOTAL_W] ? TOTAL_MAX : sum[TOTAL_W-1:0];
        total_next = total_reg;
        if (take) begin
            total_next = len.last_net ? '0 : total_sat;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            total_reg <= '0;
            valid_reg <= 1'b0;
        end else begin
            total_reg <= total_next;
            if (len_ready) valid_reg <= len_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (take) begin
            len_reg       <= len.len;
            counted_reg   <= len.counted;
            final_reg     <= len.last_net;
            out_total_reg <= total_sat;
        end
    end

    assign m_valid        = valid_reg;
    assign m_net_length   = len_reg;
    assign m_net_counted  = counted_reg;
    assign m_total_length = out_total_reg;
    assign m_is_final     = final_reg;

    a_final_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        (take && len.last_net) |=> total_reg == '0)
        else $error("total not cleared after final net");

    a_skip_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        (take && !len.counted && !len.last_net) |=>
            (total_reg == $past(total_reg) && m_total_length == $past(total_reg)))
        else $error("skipped net changed the total");

endmodule
